// ===== rtl/core/qrw_pkg.sv =====
package qrw_pkg;

    localparam int COORD_W    = 24;
    localparam int QUAT_W     = 16;
    localparam int TRACK_W    = 23;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 23;

    // dot and cross terms of a Q1.14 quaternion with a coordinate
    localparam int DOT_W   = QUAT_W + COORD_W + 2;
    localparam int CROSS_W = QUAT_W + COORD_W + 1;
    // s*s - u.u spans [-3*2^30, 2^30]
    localparam int K_W     = 2 * QUAT_W + 1;
    // partial products of one rotated coordinate
    localparam int TU_W    = DOT_W + QUAT_W;
    localparam int TK_W    = K_W + COORD_W;
    localparam int TC_W    = QUAT_W + CROSS_W;
    localparam int ACC_W   = 64;

    localparam logic signed [QUAT_W-1:0]  QUAT_W_RESET    = 16'sd16384;
    localparam logic        [TRACK_W-1:0] TRACK_RESET     = 23'd4096;
    localparam logic signed [K_W-1:0]     K_RESET         = 33'sd268435456;
    // minus 1000 m in 1/4096 m units
    localparam logic signed [COORD_W-1:0] SENTINEL_HEIGHT = -24'sd4096000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_QUAT_X       = 3'd0,
        REG_QUAT_Y       = 3'd1,
        REG_QUAT_Z       = 3'd2,
        REG_QUAT_W       = 3'd3,
        REG_TRACK_LENGTH = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
        logic                      last_point;
    } point_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] rot_x;
        logic signed [COORD_W-1:0] rot_y;
        logic signed [COORD_W-1:0] rot_z;
        logic signed [COORD_W-1:0] max_height;
        logic                      in_window;
        logic                      any_found;
        logic                      set_done;
    } result_t;

    typedef struct packed {
        logic signed [QUAT_W-1:0] quat_x;
        logic signed [QUAT_W-1:0] quat_y;
        logic signed [QUAT_W-1:0] quat_z;
        logic signed [QUAT_W-1:0] quat_w;
        logic        [TRACK_W-1:0] track_length;
        logic signed [K_W-1:0]    k;
    } coef_t;

    typedef struct packed {
        logic signed [DOT_W-1:0]   dot;
        logic signed [CROSS_W-1:0] cross_x;
        logic signed [CROSS_W-1:0] cross_y;
        logic signed [CROSS_W-1:0] cross_z;
        logic signed [COORD_W-1:0] vx;
        logic signed [COORD_W-1:0] vy;
        logic signed [COORD_W-1:0] vz;
        logic                      last_point;
    } entry_t;

endpackage

// ===== rtl/core/qrw_front.sv =====
module qrw_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [qrw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [qrw_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             push,
    output logic                             full,
    input  qrw_pkg::point_t                  item,
    input  logic                             fifo_full,
    output logic                             fifo_wr,
    output qrw_pkg::entry_t                  entry,
    output qrw_pkg::coef_t                   coef
);
    import qrw_pkg::*;

    logic signed [QUAT_W-1:0]  quat_x_reg;
    logic signed [QUAT_W-1:0]  quat_y_reg;
    logic signed [QUAT_W-1:0]  quat_z_reg;
    logic signed [QUAT_W-1:0]  quat_w_reg;
    logic        [TRACK_W-1:0] track_reg;
    logic signed [K_W-1:0]     k_reg;
    logic signed [K_W-1:0]     k_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quat_x_reg <= '0;
            quat_y_reg <= '0;
            quat_z_reg <= '0;
            quat_w_reg <= QUAT_W_RESET;
            track_reg  <= TRACK_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_QUAT_X:       quat_x_reg <= signed'(cfg_data[QUAT_W-1:0]);
                REG_QUAT_Y:       quat_y_reg <= signed'(cfg_data[QUAT_W-1:0]);
                REG_QUAT_Z:       quat_z_reg <= signed'(cfg_data[QUAT_W-1:0]);
                REG_QUAT_W:       quat_w_reg <= signed'(cfg_data[QUAT_W-1:0]);
                REG_TRACK_LENGTH: track_reg  <= cfg_data[TRACK_W-1:0];
                default:          ;
            endcase
        end
    end

    // s*s - u.u is registered and follows the quaternion in the next cycle
    assign k_next = K_W'(quat_w_reg) * K_W'(quat_w_reg)
                  - K_W'(quat_x_reg) * K_W'(quat_x_reg)
                  - K_W'(quat_y_reg) * K_W'(quat_y_reg)
                  - K_W'(quat_z_reg) * K_W'(quat_z_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            k_reg <= K_RESET;
        else
            k_reg <= k_next;
    end

    assign coef.quat_x       = quat_x_reg;
    assign coef.quat_y       = quat_y_reg;
    assign coef.quat_z       = quat_z_reg;
    assign coef.quat_w       = quat_w_reg;
    assign coef.track_length = track_reg;
    assign coef.k            = k_reg;

    assign full    = fifo_full;
    assign fifo_wr = push && !fifo_full;

    // dot and cross products go into the queue with the point
    always_comb
    begin
        entry.dot = DOT_W'(quat_x_reg) * DOT_W'(item.point_x)
                  + DOT_W'(quat_y_reg) * DOT_W'(item.point_y)
                  + DOT_W'(quat_z_reg) * DOT_W'(item.point_z);
        entry.cross_x = CROSS_W'(quat_y_reg) * CROSS_W'(item.point_z)
                      - CROSS_W'(quat_z_reg) * CROSS_W'(item.point_y);
        entry.cross_y = CROSS_W'(quat_z_reg) * CROSS_W'(item.point_x)
                      - CROSS_W'(quat_x_reg) * CROSS_W'(item.point_z);
        entry.cross_z = CROSS_W'(quat_x_reg) * CROSS_W'(item.point_y)
                      - CROSS_W'(quat_y_reg) * CROSS_W'(item.point_x);
        entry.vx         = item.point_x;
        entry.vy         = item.point_y;
        entry.vz         = item.point_z;
        entry.last_point = item.last_point;
    end

endmodule

// ===== rtl/core/qrw_fifo.sv =====
module qrw_fifo #(
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  qrw_pkg::entry_t  wr_data,
    output logic             full,
    input  logic             rd_en,
    output qrw_pkg::entry_t  rd_data,
    output logic             empty
);
    import qrw_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    entry_t           mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
            count_next = count_reg + CNT_W'(1);
        else if (rd_en && !wr_en)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (wr_en)
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (rd_en)
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue count beyond depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !full)
        else $error("write into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> !empty)
        else $error("read from empty queue");

endmodule

// ===== rtl/core/qrw_back.sv =====
module qrw_back #(
    parameter int QUAT_FRAC_BITS = 14
) (
    input  logic             clk,
    input  logic             rst_n,
    input  qrw_pkg::coef_t   coef,
    input  logic             fifo_empty,
    input  qrw_pkg::entry_t  fifo_data,
    output logic             fifo_rd,
    output logic             empty,
    input  logic             pop,
    output qrw_pkg::result_t result
);
    import qrw_pkg::*;

    localparam int SHIFT = 2 * QUAT_FRAC_BITS;
    localparam logic signed [ACC_W-1:0] HALF   = ACC_W'(64'sd1 <<< (SHIFT - 1));
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((64'sd1 <<< (COORD_W - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(64'sd1);

    function automatic logic signed [COORD_W-1:0] sat_coord(
        input logic signed [ACC_W-1:0] v
    );
        if (v > SAT_HI)
            return COORD_W'(SAT_HI);
        if (v < SAT_LO)
            return COORD_W'(SAT_LO);
        return COORD_W'(v);
    endfunction

    logic adv;

    // stage 1: queue head
    logic   b1_valid_reg;
    entry_t b1_reg;

    // stage 2: products per lane
    logic                     b2_valid_reg;
    logic                     b2_last_reg;
    logic signed [TU_W-1:0]   b2_tu_reg [3];
    logic signed [TK_W-1:0]   b2_tk_reg [3];
    logic signed [TC_W-1:0]   b2_tc_reg [3];

    // stage 3: accumulated sums
    logic                     b3_valid_reg;
    logic                     b3_last_reg;
    logic signed [ACC_W-1:0]  b3_acc_reg [3];

    // stage 4: rounded and saturated point
    logic                      b4_valid_reg;
    logic                      b4_last_reg;
    logic                      b4_inside_reg;
    logic signed [COORD_W-1:0] b4_sat_reg [3];

    // output and running state
    logic                      out_valid_reg;
    result_t                   result_reg;
    logic signed [COORD_W-1:0] max_reg;
    logic                      found_reg;

    logic signed [QUAT_W-1:0]  lane_u [3];
    logic signed [COORD_W-1:0] lane_v [3];
    logic signed [CROSS_W-1:0] lane_c [3];
    logic signed [ACC_W-1:0]   rounded [3];
    logic signed [ACC_W-1:0]   twice_x;
    logic signed [ACC_W-1:0]   track_ext;
    logic                      win_hit;
    logic signed [COORD_W-1:0] max_next;
    logic                      found_next;

    // the whole back pipeline moves when the output register can take a beat
    assign adv     = !out_valid_reg || pop;
    assign fifo_rd = adv && !fifo_empty;
    assign empty   = !out_valid_reg;
    assign result  = result_reg;

    always_comb
    begin
        lane_u[0] = coef.quat_x;
        lane_u[1] = coef.quat_y;
        lane_u[2] = coef.quat_z;
        lane_v[0] = b1_reg.vx;
        lane_v[1] = b1_reg.vy;
        lane_v[2] = b1_reg.vz;
        lane_c[0] = b1_reg.cross_x;
        lane_c[1] = b1_reg.cross_y;
        lane_c[2] = b1_reg.cross_z;
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            rounded[i] = (b3_acc_reg[i] + HALF) >>> SHIFT;
        twice_x   = rounded[0] <<< 1;
        track_ext = signed'({{(ACC_W - TRACK_W){1'b0}}, coef.track_length});
        win_hit   = (twice_x <= track_ext) && (twice_x >= -track_ext);
    end

    always_comb
    begin
        found_next = found_reg || b4_inside_reg;
        max_next   = max_reg;
        if (b4_inside_reg && (b4_sat_reg[2] > max_reg))
            max_next = b4_sat_reg[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            b2_valid_reg  <= 1'b0;
            b3_valid_reg  <= 1'b0;
            b4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            max_reg       <= SENTINEL_HEIGHT;
            found_reg     <= 1'b0;
        end
        else if (adv)
        begin
            b1_valid_reg  <= !fifo_empty;
            b2_valid_reg  <= b1_valid_reg;
            b3_valid_reg  <= b2_valid_reg;
            b4_valid_reg  <= b3_valid_reg;
            out_valid_reg <= b4_valid_reg;
            if (b4_valid_reg)
            begin
                // clear after the last point of a set has been reported
                if (b4_last_reg)
                begin
                    max_reg   <= SENTINEL_HEIGHT;
                    found_reg <= 1'b0;
                end
                else
                begin
                    max_reg   <= max_next;
                    found_reg <= found_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b1_reg <= fifo_data;

            b2_last_reg <= b1_reg.last_point;
            for (int i = 0; i < 3; i++)
            begin
                b2_tu_reg[i] <= TU_W'(b1_reg.dot) * TU_W'(lane_u[i]);
                b2_tk_reg[i] <= TK_W'(coef.k) * TK_W'(lane_v[i]);
                b2_tc_reg[i] <= TC_W'(coef.quat_w) * TC_W'(lane_c[i]);
            end

            b3_last_reg <= b2_last_reg;
            for (int i = 0; i < 3; i++)
                b3_acc_reg[i] <= (ACC_W'(b2_tu_reg[i]) <<< 1) + ACC_W'(b2_tk_reg[i])
                               + (ACC_W'(b2_tc_reg[i]) <<< 1);

            b4_last_reg   <= b3_last_reg;
            b4_inside_reg <= win_hit;
            for (int i = 0; i < 3; i++)
                b4_sat_reg[i] <= sat_coord(rounded[i]);

            result_reg.rot_x      <= b4_sat_reg[0];
            result_reg.rot_y      <= b4_sat_reg[1];
            result_reg.rot_z      <= b4_sat_reg[2];
            result_reg.max_height <= max_next;
            result_reg.in_window  <= b4_inside_reg;
            result_reg.any_found  <= found_next;
            result_reg.set_done   <= b4_last_reg;
        end
    end

    a_sentinel_until_found: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result_reg.any_found) |-> (result_reg.max_height == SENTINEL_HEIGHT))
        else $error("max height moved without a point in window");

    a_window_sets_found: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.in_window) |-> result_reg.any_found)
        else $error("point in window without found flag");

    a_set_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && b4_valid_reg && b4_last_reg) |=> (!found_reg && max_reg == SENTINEL_HEIGHT))
        else $error("running state not cleared at end of set");

endmodule

// ===== rtl/core/quaternion_rotate_window_max_z.sv =====
// Rotates a stream of points by a configured quaternion and tracks the
// highest rotated z among points whose rotated x lies within half the track
// length of the origin.
//
// Input side looks like a queue: a point is taken when push is high and full
// is low. Result side likewise: the oldest result sits on result while empty
// is low and leaves when pop is high. One result per point, in order.
// Configuration (quat_x, quat_y, quat_z, quat_w, track_length at indexes 0..4)
// is written through cfg_valid/cfg_ready; cfg_ready is always high. Write it
// only while no point is in flight; the derived s*s - u.u term is registered
// and settles in the cycle after the write.
//
// A taken point goes through the queue, the queue head, product, sum and
// rounding registers and the output register; one point per cycle while pop
// keeps up, through this multiply, add and round pipeline behind a small
// point queue. When pop is held low the back pipeline freezes once a result
// waits; the queue then fills and full rises after QUEUE_DEPTH more points.
// Reset restores the register defaults (identity quaternion, 1 m track),
// sets the running maximum to -1000 m and clears the found flag.
module quaternion_rotate_window_max_z #(
    parameter int QUAT_FRAC_BITS = 14,
    parameter int QUEUE_DEPTH    = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [qrw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [qrw_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           push,
    output logic                           full,
    input  qrw_pkg::point_t                item,
    output logic                           empty,
    input  logic                           pop,
    output qrw_pkg::result_t               result
);
    import qrw_pkg::*;

    coef_t  coef;
    entry_t wr_entry;
    entry_t rd_entry;
    logic   fifo_wr;
    logic   fifo_rd;
    logic   fifo_full;
    logic   fifo_empty;

    qrw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .item      (item),
        .fifo_full (fifo_full),
        .fifo_wr   (fifo_wr),
        .entry     (wr_entry),
        .coef      (coef)
    );

    qrw_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (fifo_wr),
        .wr_data (wr_entry),
        .full    (fifo_full),
        .rd_en   (fifo_rd),
        .rd_data (rd_entry),
        .empty   (fifo_empty)
    );

    qrw_back #(
        .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .coef       (coef),
        .fifo_empty (fifo_empty),
        .fifo_data  (rd_entry),
        .fifo_rd    (fifo_rd),
        .empty      (empty),
        .pop        (pop),
        .result     (result)
    );

endmodule

// ===== dv/rotation_monitor.sv =====
module rotation_monitor (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [qrw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [qrw_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           push,
    input  logic                           full,
    input  qrw_pkg::point_t                item,
    input  logic                           empty,
    input  logic                           pop,
    input  qrw_pkg::result_t               result,
    output int                             mismatches,
    output int                             in_flight
);
    import qrw_pkg::*;

    localparam int     FRAC      = 14;
    localparam longint COORD_TOP = (longint'(1) <<< (COORD_W - 1)) - 1;
    localparam longint COORD_BOT = -COORD_TOP - 1;

    logic signed [QUAT_W-1:0]  qx    = '0;
    logic signed [QUAT_W-1:0]  qy    = '0;
    logic signed [QUAT_W-1:0]  qz    = '0;
    logic signed [QUAT_W-1:0]  qw    = QUAT_W_RESET;
    logic        [TRACK_W-1:0] track = TRACK_RESET;
    logic signed [COORD_W-1:0] peak  = SENTINEL_HEIGHT;
    logic                      seen  = 1'b0;
    int                        err_count = 0;
    int                        pending   = 0;

    result_t rotations[$];

    assign mismatches = err_count;
    assign in_flight  = pending;

    function automatic logic signed [COORD_W-1:0] clamp(input longint v);
        if (v > COORD_TOP)
            return COORD_W'(COORD_TOP);
        if (v < COORD_BOT)
            return COORD_W'(COORD_BOT);
        return COORD_W'(v);
    endfunction

    // round half up at scale 2^(2*FRAC), floor shift
    function automatic longint round_q(input longint acc);
        return (acc + (longint'(1) <<< (2 * FRAC - 1))) >>> (2 * FRAC);
    endfunction

    function automatic longint rotate_axis(input longint dot, input longint uc,
                                           input longint kk, input longint vc,
                                           input longint cr);
        return round_q(2 * dot * uc + kk * vc + 2 * longint'(qw) * cr);
    endfunction

    // rotate one point and advance the windowed height maximum
    function automatic result_t predict_beat(input point_t p);
        longint  ux, uy, uz, s, vx, vy, vz;
        longint  dot, cx, cy, cz, kk, rx, ry, rz, tl;
        result_t r;
        ux  = qx;
        uy  = qy;
        uz  = qz;
        s   = qw;
        vx  = $signed(p.point_x);
        vy  = $signed(p.point_y);
        vz  = $signed(p.point_z);
        tl  = track;
        dot = ux * vx + uy * vy + uz * vz;
        cx  = uy * vz - uz * vy;
        cy  = uz * vx - ux * vz;
        cz  = ux * vy - uy * vx;
        kk  = s * s - (ux * ux + uy * uy + uz * uz);
        rx  = rotate_axis(dot, ux, kk, vx, cx);
        ry  = rotate_axis(dot, uy, kk, vy, cy);
        rz  = rotate_axis(dot, uz, kk, vz, cz);
        r.rot_x     = clamp(rx);
        r.rot_y     = clamp(ry);
        r.rot_z     = clamp(rz);
        // window test uses the unsaturated x
        r.in_window = (2 * rx <= tl) && (2 * rx >= -tl);
        if (r.in_window)
        begin
            seen = 1'b1;
            if (r.rot_z > peak)
                peak = r.rot_z;
        end
        r.max_height = peak;
        r.any_found  = seen;
        r.set_done   = p.last_point;
        if (p.last_point)
        begin
            peak = SENTINEL_HEIGHT;
            seen = 1'b0;
        end
        return r;
    endfunction

    task automatic check_field(input string name,
                               input logic signed [COORD_W-1:0] want,
                               input logic signed [COORD_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            err_count++;
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_QUAT_X:       qx    = cfg_data[QUAT_W-1:0];
                    REG_QUAT_Y:       qy    = cfg_data[QUAT_W-1:0];
                    REG_QUAT_Z:       qz    = cfg_data[QUAT_W-1:0];
                    REG_QUAT_W:       qw    = cfg_data[QUAT_W-1:0];
                    REG_TRACK_LENGTH: track = cfg_data[TRACK_W-1:0];
                    default: ;
                endcase
            end
            // a beat popped at this edge can never be the one pushed at it
            if (pop && !empty)
            begin
                if (rotations.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected: %h", $time, result);
                    err_count++;
                end
                else
                begin
                    want = rotations.pop_front();
                    check_field("rot_x", want.rot_x, result.rot_x);
                    check_field("rot_y", want.rot_y, result.rot_y);
                    check_field("rot_z", want.rot_z, result.rot_z);
                    check_field("max_height", want.max_height, result.max_height);
                    check_field("in_window", COORD_W'(want.in_window),
                                COORD_W'(result.in_window));
                    check_field("any_found", COORD_W'(want.any_found),
                                COORD_W'(result.any_found));
                    check_field("set_done", COORD_W'(want.set_done),
                                COORD_W'(result.set_done));
                end
            end
            if (push && !full)
                rotations.insert(rotations.size(), predict_beat(item));
            pending <= rotations.size();
        end
    end

endmodule

// ===== dv/testbench.sv =====
module testbench;
    import qrw_pkg::*;

    localparam logic signed [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W - 1){1'b1}}};
    localparam logic signed [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W - 1){1'b0}}};
    localparam logic signed [QUAT_W-1:0]  Q_ONE = 16'sd16384;
    localparam logic [TRACK_W-1:0]        TRACK_MAX     = '1;
    localparam int                        HOLD_CYCLES   = 400;
    localparam int                        RANDOM_PHASES = 8;
    localparam int                        PHASE_POINTS  = 60;
    localparam int                        HOLD_POINTS   = 30;
    localparam int                        TIMEOUT       = 400000;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  push;
    logic                  full;
    point_t                item;
    logic                  empty;
    logic                  pop = 1'b0;
    result_t               result;

    int mismatches;
    int in_flight;
    int send_idle  = 0;
    int recv_stall = 0;
    int hold_seq   = 0;
    int hold_seen  = 0;
    int hold_left  = 0;
    int points_sent   = 0;
    int sets_sent     = 0;
    int settings_used = 0;

    quaternion_rotate_window_max_z dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

    rotation_monitor rotation_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push       (push),
        .full       (full),
        .item       (item),
        .empty      (empty),
        .pop        (pop),
        .result     (result),
        .mismatches (mismatches),
        .in_flight  (in_flight)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    initial
    begin
        #(TIMEOUT);
        $display("Timeout at %0t with %0d results outstanding", $time, in_flight);
        $display("Regression FAIL");
        $finish;
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_seq != hold_seen)
        begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            pop <= 1'b0;
            hold_left--;
        end
        else
            pop <= ($urandom_range(99) >= recv_stall);
    end

    function automatic point_t pt(input logic signed [COORD_W-1:0] x,
                                  input logic signed [COORD_W-1:0] y,
                                  input logic signed [COORD_W-1:0] z,
                                  input logic last);
        point_t p;
        p.point_x    = x;
        p.point_y    = y;
        p.point_z    = z;
        p.last_point = last;
        return p;
    endfunction

    function automatic logic signed [COORD_W-1:0] pick_coord();
        case ($urandom_range(4))
            0: return COORD_W'($urandom);
            1: return COORD_W'(int'($urandom_range(16383)) - 8192);
            2: return COORD_W'(int'($urandom) >>> $urandom_range(31, 8));
            3:
            begin
                case ($urandom_range(3))
                    0: return C_MAX;
                    1: return C_MIN;
                    2: return '0;
                    default: return '1;
                endcase
            end
            default: return COORD_W'(int'($urandom_range(4095)) - 2048);
        endcase
    endfunction

    function automatic logic signed [QUAT_W-1:0] pick_quat();
        if ($urandom_range(3) == 0)
            return QUAT_W'(int'($urandom_range(2)) * 16384 - 16384);
        return QUAT_W'(int'($urandom_range(32768)) - 16384);
    endfunction

    function automatic logic [TRACK_W-1:0] pick_track();
        case ($urandom_range(3))
            0: return $urandom_range(1) ? TRACK_MAX : '0;
            1: return TRACK_W'($urandom_range(65535));
            2: return TRACK_W'($urandom_range(1 << 20));
            default: return TRACK_W'($urandom);
        endcase
    endfunction

    task automatic push_point(input point_t p);
        while ($urandom_range(99) < send_idle)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        item <= p;
        push <= 1'b1;
        @(posedge clk);
        while (full)
            @(posedge clk);
        points_sent++;
        if (p.last_point)
            sets_sent++;
    endtask

    task automatic push_random();
        push_point(pt(pick_coord(), pick_coord(), pick_coord(), $urandom_range(7) == 0));
    endtask

    // drop push and wait until every expected beat has come back
    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (in_flight != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic apply_config(input logic signed [QUAT_W-1:0] ux,
                                input logic signed [QUAT_W-1:0] uy,
                                input logic signed [QUAT_W-1:0] uz,
                                input logic signed [QUAT_W-1:0] s,
                                input logic [TRACK_W-1:0] tl);
        drain();
        write_reg(REG_QUAT_X, CFG_DATA_W'(ux));
        write_reg(REG_QUAT_Y, CFG_DATA_W'(uy));
        write_reg(REG_QUAT_Z, CFG_DATA_W'(uz));
        write_reg(REG_QUAT_W, CFG_DATA_W'(s));
        write_reg(REG_TRACK_LENGTH, CFG_DATA_W'(tl));
        cfg_valid <= 1'b0;
        // let the derived s*s - u.u term settle
        repeat (3) @(posedge clk);
        settings_used++;
    endtask

    initial
    begin
        int ph;
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        push      = 1'b0;
        item      = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: identity rotation, window of +-2048
        push_point(pt(0, 0, 0, 1'b0));
        push_point(pt(2048, 5, 100, 1'b0));
        push_point(pt(2049, 1, 999, 1'b0));
        push_point(pt(-2048, -1, -50, 1'b0));
        push_point(pt(-2049, 3, 777, 1'b0));
        push_point(pt(C_MAX, C_MAX, C_MAX, 1'b0));
        push_point(pt(C_MIN, C_MIN, C_MIN, 1'b1));
        // in window at exactly the sentinel height
        push_point(pt(0, 0, SENTINEL_HEIGHT, 1'b0));
        push_point(pt(10, 0, 20, 1'b1));
        // set with no point in the window
        push_point(pt(5000, 0, 0, 1'b1));

        // non-unit quaternion, widest window: saturation
        apply_config(Q_ONE, Q_ONE, Q_ONE, Q_ONE, TRACK_MAX);
        push_point(pt(C_MAX, C_MAX, C_MAX, 1'b0));
        push_point(pt(C_MIN, C_MIN, C_MIN, 1'b0));
        push_point(pt(C_MAX, C_MIN, 0, 1'b0));
        push_point(pt(1, -1, 1, 1'b1));

        // negative scalar, zero-width window
        apply_config(0, 0, 0, -Q_ONE, '0);
        push_point(pt(0, 7, -7, 1'b0));
        push_point(pt(1, 0, 5, 1'b0));
        push_point(pt(-1, 0, 5, 1'b1));

        apply_config(-Q_ONE, Q_ONE, -Q_ONE, 0, 1);
        push_point(pt(C_MAX, C_MIN, C_MAX, 1'b0));
        push_point(pt(0, 0, 1, 1'b1));

        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            apply_config(pick_quat(), pick_quat(), pick_quat(), pick_quat(), pick_track());
            case (ph % 4)
                0:
                begin
                    send_idle  = 0;
                    recv_stall = 0;
                end
                1:
                begin
                    send_idle  = 78;
                    recv_stall = 0;
                end
                2:
                begin
                    send_idle  = 0;
                    recv_stall = 78;
                end
                default:
                begin
                    send_idle  = 20;
                    recv_stall = 20;
                end
            endcase
            repeat (PHASE_POINTS) push_random();
        end

        // hold the receiver off while the sender keeps offering beats
        apply_config(pick_quat(), pick_quat(), pick_quat(), Q_ONE, pick_track());
        send_idle  = 0;
        recv_stall = 0;
        hold_seq++;
        repeat (HOLD_POINTS) push_random();
        drain();

        $display("Covered %0d points in %0d sets across %0d register settings,",
                 points_sent, sets_sent, settings_used);
        $display("with sender gaps, receiver stalls and a long receiver hold-off.");
        if (mismatches == 0 && in_flight == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/qrw_pkg.sv
rtl/core/qrw_front.sv
rtl/core/qrw_fifo.sv
rtl/core/qrw_back.sv
rtl/core/quaternion_rotate_window_max_z.sv
dv/rotation_monitor.sv
dv/testbench.sv
